@@ rtl/bitrev_pkg.sv @@
// shared types and constants for the fft bit-reversal reorder buffer
`default_nettype none
package bitrev_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int SAMPLE_W   = 16;
	localparam int LP_W       = 4;
	localparam int LOG2_MAX   = $clog2(MAX_POINTS);
	localparam int POS_W      = LOG2_MAX;
	localparam int ADDR_W     = POS_W + 1;
	localparam int BANK_DEPTH = 2 * MAX_POINTS;
	localparam int WORD_W     = 2 * SAMPLE_W;
	localparam int CMD_DEPTH  = 4;
	localparam int OUT_DEPTH  = 2;
	localparam logic [LP_W-1:0] LOG2_RESET = LP_W'(3);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	// one memory operation pair for the back end
	typedef struct packed {
		logic              write_en;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              read_en;
		logic [ADDR_W-1:0] raddr;
		logic              last;
	} cmd_t;

	typedef struct packed {
		sample_t re;
		sample_t im;
		logic    last;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/bitrev_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none
module bitrev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/bitrev_front.sv @@
// front end: frame position, bank select and address generation per input transaction
`default_nettype none
module bitrev_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr,
	input  wire logic [bitrev_pkg::LP_W-1:0]  cfg_log2,
	input  wire logic                         accept,
	input  wire logic                         op,
	input  wire bitrev_pkg::sample_t          sample_real,
	input  wire bitrev_pkg::sample_t          sample_imag,
	output bitrev_pkg::cmd_t                  cmd
);

	import bitrev_pkg::*;

	localparam logic [POS_W-1:0] POS_ONES = '1;

	logic [LP_W-1:0]  log2_q;
	logic [POS_W-1:0] pos_q;
	logic             bank_q;
	logic             held_q;
	logic             broken_q;

	logic [LP_W-1:0]  lp_eff;
	logic [POS_W-1:0] pos_mask;
	logic [POS_W-1:0] rev_full;
	logic [POS_W-1:0] rev_pos;
	logic             is_last;
	logic             is_drain;

	always_comb begin
		if (log2_q == '0) begin
			lp_eff = LP_W'(1);
		end else if (log2_q > LP_W'(LOG2_MAX)) begin
			lp_eff = LP_W'(LOG2_MAX);
		end else begin
			lp_eff = log2_q;
		end
	end

	always_comb begin
		for (int i = 0; i < POS_W; i++) begin
			rev_full[i] = pos_q[POS_W-1-i];
		end
	end

	// reversal over lp bits: full reversal then drop the unused low bits
	assign rev_pos  = rev_full >> (LP_W'(POS_W) - lp_eff);
	assign pos_mask = ~(POS_ONES << lp_eff);
	assign is_last  = (pos_q == pos_mask);
	assign is_drain = (op == OP_DRAIN);

	always_comb begin
		cmd.write_en = !is_drain;
		cmd.waddr    = {bank_q, pos_q};
		cmd.wdata    = {sample_real, sample_imag};
		cmd.read_en  = held_q;
		cmd.raddr    = {~bank_q, rev_pos};
		cmd.last     = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q   <= LOG2_RESET;
			pos_q    <= '0;
			bank_q   <= 1'b0;
			held_q   <= 1'b0;
			broken_q <= 1'b0;
		end else if (cfg_wr) begin
			// restart: bank contents and bank select stay
			log2_q   <= cfg_log2;
			pos_q    <= '0;
			held_q   <= 1'b0;
			broken_q <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				pos_q    <= '0;
				broken_q <= 1'b0;
				if (broken_q || is_drain) begin
					held_q <= 1'b0;
				end else begin
					bank_q <= ~bank_q;
					held_q <= 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
				if (is_drain) begin
					broken_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bitrev_queue.sv @@
// command queue between front and back end
`default_nettype none
module bitrev_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bitrev_pkg::cmd_t din,
	input  wire logic             pop,
	output bitrev_pkg::cmd_t      dout,
	output logic                  not_empty,
	output logic                  full
);

	import bitrev_pkg::*;

	localparam int PTR_W = $clog2(CMD_DEPTH);
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             slot_q [CMD_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	assign dout      = slot_q[head_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(CMD_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/bitrev_back.sv @@
// back end: executes bank writes and reads in order, buffers results for the output
`default_nettype none
module bitrev_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bitrev_pkg::cmd_t cmd,
	input  wire logic             cmd_valid,
	output logic                  cmd_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output bitrev_pkg::result_t   result
);

	import bitrev_pkg::*;

	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1) + 1;

	logic [WORD_W-1:0] rdata;
	logic              ram_we;
	logic              ram_re;
	logic              valid_s1;
	logic              last_s1;

	result_t           obuf_q [OUT_DEPTH];
	logic [OPTR_W-1:0] ohead_q;
	logic [OPTR_W-1:0] otail_q;
	logic [OCNT_W-1:0] ocount_q;
	logic              deq;
	logic [OCNT_W-1:0] room_used;
	logic              can_read;

	bitrev_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BANK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.waddr),
		.wdata (cmd.wdata),
		.re    (ram_re),
		.raddr (cmd.raddr),
		.rdata (rdata)
	);

	assign out_valid = (ocount_q != '0);
	assign result    = obuf_q[ohead_q];
	assign deq       = out_valid && !out_stall;

	// a read may issue only if its result has a buffer slot when it lands
	assign room_used = ocount_q + OCNT_W'(valid_s1) - OCNT_W'(deq);
	assign can_read  = (room_used < OCNT_W'(OUT_DEPTH));
	assign cmd_pop   = cmd_valid && (!cmd.read_en || can_read);
	assign ram_we    = cmd_pop && cmd.write_en;
	assign ram_re    = cmd_pop && cmd.read_en;

	always_ff @(posedge clk) begin
		if (ram_re) begin
			last_s1 <= cmd.last;
		end
		if (valid_s1) begin
			obuf_q[otail_q] <= '{re: rdata[WORD_W-1:SAMPLE_W], im: rdata[SAMPLE_W-1:0],
				last: last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ohead_q  <= '0;
			otail_q  <= '0;
			ocount_q <= '0;
		end else begin
			valid_s1 <= ram_re;
			if (valid_s1) begin
				otail_q <= (otail_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : otail_q + 1'b1;
			end
			if (deq) begin
				ohead_q <= (ohead_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ohead_q + 1'b1;
			end
			unique case ({valid_s1, deq})
				2'b10:   ocount_q <= ocount_q + 1'b1;
				2'b01:   ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/fft_bit_reverse_reorder_unit.sv @@
// top level of the streaming fft bit-reversal reorder buffer
// Takes one complex sample (or drain tick) per cycle unless stalled and returns,
// for every transaction while a complete frame is held, one element of that
// frame at the bit-reversed position, flagged on the frame's last element.
// Sustained rate is one transaction per clock while out_stall is low; results
// pass the command queue, bank read and output buffer. The front end holds frame
// position and bank select and feeds a four-entry command queue; the back end
// does the bank write and bit-reversed read in order on a 2048 x 32 memory with
// one write and one read port, so in_stall only rises when that queue is full
// because the output side is stalled. log2_points of 0 acts as 1 and values
// above 10 act as 10; any write restarts framing and discards the held frame.
// The banks are not cleared after reset, as no read reaches an unwritten entry.
`default_nettype none
module fft_bit_reverse_reorder_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bitrev_pkg::LP_W-1:0] log2_points,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        op,
	input  wire bitrev_pkg::sample_t         sample_real,
	input  wire bitrev_pkg::sample_t         sample_imag,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output bitrev_pkg::sample_t              out_real,
	output bitrev_pkg::sample_t              out_imag,
	output logic                             last_of_frame
);

	import bitrev_pkg::*;

	cmd_t    front_cmd;
	cmd_t    back_cmd;
	logic    accept;
	logic    q_full;
	logic    q_not_empty;
	logic    q_pop;
	result_t result;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	bitrev_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_log2    (log2_points),
		.accept      (accept),
		.op          (op),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.cmd         (front_cmd)
	);

	bitrev_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (front_cmd),
		.pop       (q_pop),
		.dout      (back_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	bitrev_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (q_not_empty),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign out_real      = result.re;
	assign out_imag      = result.im;
	assign last_of_frame = result.last;

endmodule
`default_nettype wire

@@ rtl/bitrev_checker.sv @@
// port-level checker for the reorder buffer, bound to the top level
`default_nettype none
module bitrev_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [bitrev_pkg::LP_W-1:0] log2_points,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        op,
	input wire bitrev_pkg::sample_t         sample_real,
	input wire bitrev_pkg::sample_t         sample_imag,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire bitrev_pkg::sample_t         out_real,
	input wire bitrev_pkg::sample_t         out_imag,
	input wire logic                        last_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_real) && $stable(out_imag)
			&& $stable(last_of_frame))
		else $error("stalled result changed or dropped");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(op) && $stable(sample_real)
			&& $stable(sample_imag))
		else $error("stalled input transaction changed or dropped");

	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid, cfg_ready}))
		else $error("handshake output unknown");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({out_real, out_imag, last_of_frame}))
		else $error("result payload unknown");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(log2_points))
		else $error("configuration write refused");

endmodule

bind fft_bit_reverse_reorder_unit bitrev_checker u_bitrev_checker (.*);
`default_nettype wire

@@ tb/fft_bit_reverse_reorder_unit_tb.sv @@
// self-checking testbench for the fft bit-reversal reorder buffer
`timescale 1ns / 1ps
module fft_bit_reverse_reorder_unit_tb;
	import bitrev_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 150;
	localparam int CFG_SETTLE   = 16;
	localparam int TAIL_CYCLES  = 20;
	localparam int GAP_PCT      = 28;

	class reorder_scoreboard;
		sample_t           bank_re[2][MAX_POINTS];
		sample_t           bank_im[2][MAX_POINTS];
		bit                wsel = 1'b0;
		int unsigned       pos = 0;
		bit                held = 1'b0;
		bit                broken = 1'b0;
		logic [LP_W-1:0]   lp_reg = LOG2_RESET;
		result_t           pending_elems[$];
		int                errors = 0;

		function int pending();
			return pending_elems.size();
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		endtask

		function void apply_log2(logic [LP_W-1:0] v);
			lp_reg = v;
			pos = 0;
			held = 1'b0;
			broken = 1'b0;
		endfunction

		// walks one transaction through the reorder buffer, queueing the element it emits
		function void note_item(op_t kind, sample_t re, sample_t im);
			int unsigned lp, len, p, ra, b;
			result_t r;
			lp = lp_reg;
			if (lp == 0)
				lp = 1;
			if (lp > LOG2_MAX)
				lp = LOG2_MAX;
			len = 1 << lp;
			p = (pos >= len) ? 0 : pos;
			if (held) begin
				ra = 0;
				for (b = 0; b < lp; b++)
					ra = (ra << 1) | ((p >> b) & 1);
				r.re = bank_re[!wsel][ra];
				r.im = bank_im[!wsel][ra];
				r.last = (p == len - 1);
				pending_elems.push_back(r);
			end
			if (kind == OP_DRAIN) begin
				broken = 1'b1;
			end else begin
				bank_re[wsel][p] = re;
				bank_im[wsel][p] = im;
			end
			p++;
			if (p >= len) begin
				p = 0;
				if (broken) begin
					held = 1'b0;
					broken = 1'b0;
				end else begin
					wsel = !wsel;
					held = 1'b1;
				end
			end
			pos = p;
		endfunction

		task check_result(sample_t re, sample_t im, logic last);
			result_t w;
			if (pending_elems.size() == 0) begin
				report("result with nothing pending", re, 0);
				return;
			end
			w = pending_elems.pop_front();
			if (re !== w.re)
				report("out_real", re, w.re);
			if (im !== w.im)
				report("out_imag", im, w.im);
			if (last !== w.last)
				report("last_of_frame", last, w.last);
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [LP_W-1:0] log2_points = LOG2_RESET;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            op = OP_SAMPLE;
	sample_t         sample_real = '0;
	sample_t         sample_imag = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	sample_t         out_real;
	sample_t         out_imag;
	logic            last_of_frame;

	reorder_scoreboard sb = new();
	bit steady = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;

	fft_bit_reverse_reorder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.log2_points   (log2_points),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.sample_real   (sample_real),
		.sample_imag   (sample_imag),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_real      (out_real),
		.out_imag      (out_imag),
		.last_of_frame (last_of_frame)
	);

	always #2 clk = ~clk;

	function automatic sample_t pick_sample();
		sample_t corner[4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
		if ($urandom_range(7) == 0)
			return corner[$urandom_range(3)];
		return sample_t'($urandom);
	endfunction

	task automatic send_item(input op_t kind, input sample_t re, input sample_t im);
		while (!steady && $urandom_range(99) < GAP_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		sample_real <= re;
		sample_imag <= im;
		do @(posedge clk); while (in_stall);
		sb.note_item(kind, re, im);
	endtask

	// register writes only happen once the buffer has drained
	task automatic write_log2(input logic [LP_W-1:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		log2_points <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.apply_log2(v);
	endtask

	task automatic run_phase(input logic [LP_W-1:0] v, input int n_items, input int drain_pct,
			input int hold_at);
		int i;
		write_log2(v);
		for (i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			if ($urandom_range(99) < drain_pct)
				send_item(OP_DRAIN, pick_sample(), pick_sample());
			else
				send_item(OP_SAMPLE, pick_sample(), pick_sample());
		end
	endtask

	initial begin : rx_side
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				// long hold-off so the queue fills and the input side stalls
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !steady && ($urandom_range(99) < GAP_PCT);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_real, out_imag, last_of_frame);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** fft_bit_reverse_reorder_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin : tx_side
		sample_t corner_vals[8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
			16'sh5555, sample_t'(16'hAAAA), 16'sh0001, 16'sh00FF};
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame length of 8: drain with nothing held breaks the first frame
		send_item(OP_DRAIN, 16'sh7FFF, 16'sh8000);
		for (i = 1; i < 8; i++)
			send_item(OP_SAMPLE, sample_t'(i), -sample_t'(i));
		for (i = 0; i < 8; i++)
			send_item(OP_SAMPLE, corner_vals[i], corner_vals[7 - i]);
		for (i = 0; i < 8; i++)
			send_item(OP_SAMPLE, pick_sample(), pick_sample());
		// drain while a frame is held still emits and drops the frame being written
		send_item(OP_DRAIN, pick_sample(), pick_sample());

		run_phase(4'd1, 40, 5, -1);
		run_phase(4'd0, 30, 10, -1);
		run_phase(4'd2, 60, 4, -1);
		run_phase(4'd4, 100, 0, 40);
		steady = 1'b1;
		run_phase(4'd5, 80, 2, -1);
		steady = 1'b0;
		run_phase(4'd3, 60, 30, -1);
		run_phase(4'd12, 20, 0, -1);
		run_phase(4'd15, 20, 0, -1);
		run_phase(4'd6, 128, 2, -1);

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** fft_bit_reverse_reorder_unit: PASSED **");
		else
			$display("** fft_bit_reverse_reorder_unit: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bitrev_pkg.sv
rtl/bitrev_ram.sv
rtl/bitrev_front.sv
rtl/bitrev_queue.sv
rtl/bitrev_back.sv
rtl/fft_bit_reverse_reorder_unit.sv
rtl/bitrev_checker.sv
tb/fft_bit_reverse_reorder_unit_tb.sv
